/* rtl/core/nad_pkg.sv */
// Package for the normalised attribute distance block: field widths, fixed-point
// constants, register indexes, and the attribute kind and difference class types.
// No dependencies.
package nad_pkg;

    localparam int VALUE_W   = 32;
    localparam int SCALE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIST_W    = 48;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 1;
    localparam int PROD_W    = VALUE_W + SCALE_W;

    localparam int S_TDATA_W = 2 * VALUE_W + SCALE_W;
    localparam int S_TUSER_W = 2 + KIND_W;
    localparam int M_TDATA_W = ((DIST_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] ONE_FX   = DIST_W'(1) << FRAC_BITS;
    localparam logic [DIST_W-1:0] HALF_FX  = DIST_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_IGNORED  = 2'd0,
        KIND_CONT     = 2'd1,
        KIND_DISCRETE = 2'd2,
        KIND_RESERVED = 2'd3
    } t_attr_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REDUCE_MODE     = 2'd0,
        CFG_NORMALIZE_ON    = 2'd1,
        CFG_IGNORE_UNKNOWNS = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIFF_ZERO = 2'd0,
        DIFF_HALF = 2'd1,
        DIFF_ONE  = 2'd2,
        DIFF_CONT = 2'd3
    } t_diff_cls;

endpackage

/* rtl/core/normalized_attribute_distance.sv */
// Normalised attribute distance, Manhattan or maximal, Q16.16 in, Q32.16 out.
// Four-stage pipeline: input register, difference, multiply, reduce.
// Depends on nad_pkg.
//
// channel   dir  tdata                                   tuser                    tlast
// s_axis    in   value_a, value_b, scale (96 bits)       unknown_a, unknown_b,    last
//                                                        attr_kind
// m_axis    out  distance (48 bits)                      saturated                -
// i_cfg_*   in   index 0 reduce_mode, 1 normalize_on, 2 ignore_unknowns
//
// One request per cycle sustained while the output takes results; a result is offered
// once its last request has passed the input, difference and multiply registers.
// The running total loop is the only feedback path: one add or compare per cycle while stage 4 advances.
// Reset clears the running total, the pipeline valids and the registers to defaults.
// A stalled result holds the reduce stage only for last requests; bubbles in front
// of it keep absorbing new requests.
module normalized_attribute_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [nad_pkg::S_TDATA_W-1:0] s_axis_tdata,  // value_a, value_b, scale
    input  logic [nad_pkg::S_TUSER_W-1:0] s_axis_tuser,  // unknown_a, unknown_b, attr_kind
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [nad_pkg::M_TDATA_W-1:0] m_axis_tdata,  // distance
    output logic                          m_axis_tuser,  // saturated
    input  logic                          i_cfg_we,
    input  logic [nad_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nad_pkg::CFG_DAT_W-1:0] i_cfg_wdata
);
    import nad_pkg::*;

    logic r_reduce_mode, r_normalize_on, r_ignore_unk;

    logic                      r_s1_v, r_s1_unk, r_s1_last;
    logic signed [VALUE_W-1:0] r_s1_a, r_s1_b;
    logic [SCALE_W-1:0]        r_s1_scale;
    t_attr_kind                r_s1_kind;

    logic               r_s2_v, r_s2_last;
    logic [VALUE_W-1:0] r_s2_mag;
    logic [SCALE_W-1:0] r_s2_scale;
    t_diff_cls          r_s2_cls;

    logic              r_s3_v, r_s3_last;
    logic [DIST_W-1:0] r_s3_d;

    logic [DIST_W-1:0] r_total;
    logic              r_ovf;
    logic              r_out_v, r_out_sat;
    logic [DIST_W-1:0] r_out_dist;

    logic              out_free, acc_go, s3_adv, s2_adv, s1_adv;
    logic [VALUE_W:0]  diff;
    logic [VALUE_W-1:0] n_mag;
    t_diff_cls         n_cls;
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] n_d;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] n_red;
    logic              n_clamp;

    assign out_free      = !r_out_v || m_axis_tready;
    assign acc_go        = r_s3_v && (!r_s3_last || out_free);
    assign s3_adv        = !r_s3_v || acc_go;
    assign s2_adv        = !r_s2_v || s3_adv;
    assign s1_adv        = !r_s1_v || s2_adv;
    assign s_axis_tready = s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reduce_mode  <= 1'b0;
            r_normalize_on <= 1'b1;
            r_ignore_unk   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_REDUCE_MODE:     r_reduce_mode  <= i_cfg_wdata[0];
                CFG_NORMALIZE_ON:    r_normalize_on <= i_cfg_wdata[0];
                CFG_IGNORE_UNKNOWNS: r_ignore_unk   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_adv) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_a     <= s_axis_tdata[VALUE_W-1:0];
            r_s1_b     <= s_axis_tdata[2*VALUE_W-1:VALUE_W];
            r_s1_scale <= s_axis_tdata[2*VALUE_W+SCALE_W-1:2*VALUE_W];
            r_s1_unk   <= s_axis_tuser[0] | s_axis_tuser[1];
            r_s1_kind  <= t_attr_kind'(s_axis_tuser[2+KIND_W-1:2]);
            r_s1_last  <= s_axis_tlast;
        end
    end

    // stage 2: magnitude and difference class
    always_comb begin
        diff  = {r_s1_a[VALUE_W-1], r_s1_a} - {r_s1_b[VALUE_W-1], r_s1_b};
        n_mag = diff[VALUE_W] ? VALUE_W'(-diff) : diff[VALUE_W-1:0];
        n_cls = DIFF_ZERO;
        if (r_s1_unk) begin
            if ((r_s1_kind == KIND_CONT || r_s1_kind == KIND_DISCRETE) && !r_ignore_unk)
                n_cls = DIFF_HALF;
        end else begin
            case (r_s1_kind)
                KIND_CONT:     n_cls = DIFF_CONT;
                KIND_DISCRETE: n_cls = (r_s1_a != r_s1_b) ? DIFF_ONE : DIFF_ZERO;
                default:       n_cls = DIFF_ZERO;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_s2_mag   <= n_mag;
            r_s2_scale <= r_s1_scale;
            r_s2_cls   <= n_cls;
            r_s2_last  <= r_s1_last;
        end
    end

    // stage 3: per-attribute distance, continuous differences scaled when normalize_on is set
    always_comb begin
        prod = PROD_W'(r_s2_mag) * PROD_W'(r_s2_scale);
        case (r_s2_cls)
            DIFF_HALF: n_d = HALF_FX;
            DIFF_ONE:  n_d = ONE_FX;
            DIFF_CONT: n_d = r_normalize_on ? prod[FRAC_BITS +: DIST_W] : DIST_W'(r_s2_mag);
            default:   n_d = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (s3_adv) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_s3_d    <= n_d;
            r_s3_last <= r_s2_last;
        end
    end

    // stage 4: reduce into the running total
    always_comb begin
        sum     = {1'b0, r_total} + {1'b0, r_s3_d};
        n_clamp = 1'b0;
        if (!r_reduce_mode) begin
            if (sum[DIST_W]) begin
                n_red   = DIST_MAX;
                n_clamp = 1'b1;
            end else begin
                n_red = sum[DIST_W-1:0];
            end
        end else begin
            n_red = (r_s3_d > r_total) ? r_s3_d : r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (acc_go) begin
            r_total <= r_s3_last ? '0 : n_red;
            r_ovf   <= r_s3_last ? 1'b0 : (r_ovf | n_clamp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (acc_go && r_s3_last) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_go && r_s3_last) begin
            r_out_dist <= n_red;
            r_out_sat  <= r_ovf | n_clamp;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = M_TDATA_W'(r_out_dist);
    assign m_axis_tuser  = r_out_sat;

endmodule
